// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the channel RTL.
// Expects signals named clk and rst_n in the scope of use; empty under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define DSC_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("%m: invariant violated");
`define DSC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication violated");
`define DSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check violated");
`else
`define DSC_ASSERT_ALWAYS(label, expr)
`define DSC_ASSERT_IMPLY(label, ante, cons)
`define DSC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/core/dsc_pkg.sv -----
// Package for the delta sample channel: request and result types, codes and rate tables.
// Used by dsc_core and delta_sample_channel_top; depends on nothing.
`default_nettype none

package dsc_pkg;

  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_WRITE   = 3'd1;
  localparam logic [2:0] ACT_STATUS  = 3'd2;
  localparam logic [2:0] ACT_DMA     = 3'd3;
  localparam logic [2:0] ACT_IRQ_ACK = 3'd4;

  localparam logic [2:0] REG_CONTROL = 3'd0;
  localparam logic [2:0] REG_LEVEL   = 3'd1;
  localparam logic [2:0] REG_START   = 3'd2;
  localparam logic [2:0] REG_LENGTH  = 3'd3;
  localparam logic [2:0] REG_ENABLE  = 3'd4;

  localparam logic [1:0] TV_PAL = 2'd1;

  localparam logic [15:0] ADDR_RESET = 16'hC000;
  localparam logic [15:0] ADDR_WRAP  = 16'h8000;
  localparam logic [15:0] ADDR_LAST  = 16'hFFFF;
  localparam logic [6:0]  LEVEL_TOP  = 7'h7D;

  localparam logic [8:0] NTSC_RATE [16] = '{
    9'd428, 9'd380, 9'd340, 9'd320, 9'd286, 9'd254, 9'd226, 9'd214,
    9'd190, 9'd160, 9'd142, 9'd128, 9'd106, 9'd84,  9'd72,  9'd54
  };
  localparam logic [8:0] PAL_RATE [16] = '{
    9'd398, 9'd354, 9'd316, 9'd298, 9'd276, 9'd236, 9'd210, 9'd198,
    9'd176, 9'd148, 9'd132, 9'd118, 9'd98,  9'd78,  9'd66,  9'd50
  };

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] reg_select;
    logic [7:0] data_byte;
  } dsc_req_t;

  typedef struct packed {
    logic        bytes_active;
    logic [15:0] fetch_address;
    logic        dma_request;
    logic        irq_pending;
    logic [6:0]  sample_level;
  } dsc_result_t;

  typedef struct packed {
    logic irq_enable;
    logic irq_flag;
  } dsc_status_t;

  function automatic logic [8:0] rate_period(input logic [1:0] tv, input logic [3:0] idx);
    rate_period = (tv == TV_PAL) ? PAL_RATE[idx] : NTSC_RATE[idx];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/delta_sample_channel_top.sv -----
// Top level of the delta sample channel: request register, channel core, result register.
// Depends on dsc_pkg, dsc_core and assert_macros.svh.
// The channel takes one request per clock unless the result stalls, and gives one
// result for each: the request is captured in an input register, the core updates all
// channel state in a single pass, and the result lands in an output register. A stalled
// result holds the core, and the input register still takes a request when the result
// drains in the same cycle. tv_system selects the PAL rate table for code 1 and the NTSC
// table otherwise; write it only while no request is in flight.
`default_nettype none

module delta_sample_channel_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata,     // tv_system
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // data_byte
  input  wire logic [5:0]  in_tuser,      // action [2:0], reg_select [5:3]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata      // sample_level [6:0], irq_pending [7],
                                          // dma_request [8], fetch_address [24:9],
                                          // bytes_active [25], zero [31:26]
);

  logic [1:0]           tv_r;
  dsc_pkg::dsc_req_t    in_req_r;
  logic                 in_valid_r,  in_valid_nxt;
  dsc_pkg::dsc_result_t out_res_r;
  logic                 out_valid_r, out_valid_nxt;
  dsc_pkg::dsc_result_t core_res;
  dsc_pkg::dsc_status_t core_status;
  logic                 advance;
  logic                 in_fire;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt  = in_fire ? 1'b1 : (advance ? 1'b0 : in_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r        <= 2'd0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        tv_r <= cfg_wdata;
      end
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_req_r.action     <= in_tuser[2:0];
      in_req_r.reg_select <= in_tuser[5:3];
      in_req_r.data_byte  <= in_tdata;
    end
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  dsc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .tv_system (tv_r),
    .fire      (advance),
    .req       (in_req_r),
    .result    (core_res),
    .status    (core_status)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, out_res_r};

`include "assert_macros.svh"

  `DSC_ASSERT_ALWAYS(a_irq_needs_enable, !core_status.irq_flag || core_status.irq_enable)
  `DSC_ASSERT_IMPLY(a_dma_has_bytes, out_valid_r && out_res_r.dma_request, out_res_r.bytes_active)
  `DSC_ASSERT_IMPLY(a_addr_upper_half, out_valid_r, out_res_r.fetch_address[15])
  `DSC_ASSERT_IMPLY(a_full_stage_moves, in_valid_r && in_tready, advance)

endmodule

`default_nettype wire

// ----- rtl/core/dsc_core.sv -----
// Channel state registers and the single-pass update for one request.
// Depends on dsc_pkg.
`default_nettype none

module dsc_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [1:0]          tv_system,
  input  wire logic                fire,
  input  wire dsc_pkg::dsc_req_t   req,
  output dsc_pkg::dsc_result_t     result,
  output dsc_pkg::dsc_status_t     status
);

  logic [8:0]  timer_r,      timer_nxt;
  logic [6:0]  level_cnt_r,  level_cnt_nxt;
  logic [6:0]  level_out_r,  level_out_nxt;
  logic [7:0]  shift_r,      shift_nxt;
  logic [3:0]  bits_r,       bits_nxt;
  logic        shifting_r,   shifting_nxt;
  logic        buf_full_r,   buf_full_nxt;
  logic [7:0]  sample_buf_r, sample_buf_nxt;
  logic [11:0] bytes_r,      bytes_nxt;
  logic [15:0] addr_r,       addr_nxt;
  logic        irq_en_r,     irq_en_nxt;
  logic        loop_r,       loop_nxt;
  logic [3:0]  rate_idx_r,   rate_idx_nxt;
  logic [15:0] start_r,      start_nxt;
  logic [11:0] reload_r,     reload_nxt;
  logic        irq_r,        irq_nxt;
  logic        dma_req;
  logic [11:0] bytes_dec;

  always_comb begin
    timer_nxt      = timer_r;
    level_cnt_nxt  = level_cnt_r;
    level_out_nxt  = level_out_r;
    shift_nxt      = shift_r;
    bits_nxt       = bits_r;
    shifting_nxt   = shifting_r;
    buf_full_nxt   = buf_full_r;
    sample_buf_nxt = sample_buf_r;
    bytes_nxt      = bytes_r;
    addr_nxt       = addr_r;
    irq_en_nxt     = irq_en_r;
    loop_nxt       = loop_r;
    rate_idx_nxt   = rate_idx_r;
    start_nxt      = start_r;
    reload_nxt     = reload_r;
    irq_nxt        = irq_r;
    dma_req        = 1'b0;
    bytes_dec      = (bytes_r != 12'd0) ? bytes_r - 12'd1 : 12'd0;

    case (req.action)
      dsc_pkg::ACT_TICK: begin
        if (timer_r > 9'd1) begin
          timer_nxt = timer_r - 9'd1;
        end else begin
          timer_nxt = dsc_pkg::rate_period(tv_system, rate_idx_r);
          if (shifting_r) begin
            if (shift_r[0]) begin
              if (level_cnt_r <= dsc_pkg::LEVEL_TOP) level_cnt_nxt = level_cnt_r + 7'd2;
            end else begin
              if (level_cnt_r >= 7'd2) level_cnt_nxt = level_cnt_r - 7'd2;
            end
            shift_nxt = {1'b0, shift_r[7:1]};
          end
          bits_nxt = bits_r - 4'd1;
          if (bits_nxt == 4'd0) begin
            bits_nxt = 4'd8;
            if (buf_full_r) begin
              buf_full_nxt = 1'b0;
              shifting_nxt = 1'b1;
              shift_nxt    = sample_buf_r;
              dma_req      = (bytes_r != 12'd0);
            end else begin
              shifting_nxt = 1'b0;
            end
          end
          level_out_nxt = level_cnt_nxt;
        end
      end
      dsc_pkg::ACT_WRITE: begin
        case (req.reg_select)
          dsc_pkg::REG_CONTROL: begin
            irq_en_nxt   = req.data_byte[7];
            loop_nxt     = req.data_byte[6];
            rate_idx_nxt = req.data_byte[3:0];
            if (!req.data_byte[7]) irq_nxt = 1'b0;
          end
          dsc_pkg::REG_LEVEL: begin
            level_cnt_nxt = req.data_byte[6:0];
          end
          dsc_pkg::REG_START: begin
            start_nxt = dsc_pkg::ADDR_RESET | {2'b00, req.data_byte, 6'b000000};
          end
          dsc_pkg::REG_LENGTH: begin
            reload_nxt = {req.data_byte, 4'b0001};
          end
          dsc_pkg::REG_ENABLE: begin
            irq_nxt = 1'b0;
            if (req.data_byte[4]) begin
              if (bytes_r == 12'd0) begin
                bytes_nxt = reload_r;
                addr_nxt  = start_r;
              end
            end else begin
              bytes_nxt = 12'd0;
            end
            dma_req = !buf_full_r && (bytes_nxt != 12'd0);
          end
          default: begin
          end
        endcase
      end
      dsc_pkg::ACT_DMA: begin
        buf_full_nxt   = 1'b1;
        sample_buf_nxt = req.data_byte;
        addr_nxt       = (addr_r == dsc_pkg::ADDR_LAST) ? dsc_pkg::ADDR_WRAP : addr_r + 16'd1;
        bytes_nxt      = bytes_dec;
        if (bytes_dec == 12'd0) begin
          if (loop_r) begin
            bytes_nxt = reload_r;
            addr_nxt  = start_r;
          end else if (irq_en_r) begin
            irq_nxt = 1'b1;
          end
        end
      end
      dsc_pkg::ACT_IRQ_ACK: begin
        irq_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.sample_level  = level_out_nxt;
    result.irq_pending   = irq_nxt;
    result.dma_request   = dma_req;
    result.fetch_address = addr_nxt;
    result.bytes_active  = (bytes_nxt != 12'd0);
    status.irq_enable    = irq_en_r;
    status.irq_flag      = irq_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r     <= 9'd0;
      level_cnt_r <= 7'd0;
      level_out_r <= 7'd0;
      shift_r     <= 8'd1;
      bits_r      <= 4'd1;
      shifting_r  <= 1'b0;
      buf_full_r  <= 1'b0;
      bytes_r     <= 12'd0;
      addr_r      <= dsc_pkg::ADDR_RESET;
      irq_en_r    <= 1'b0;
      loop_r      <= 1'b0;
      rate_idx_r  <= 4'd0;
      start_r     <= dsc_pkg::ADDR_RESET;
      reload_r    <= 12'd0;
      irq_r       <= 1'b0;
    end else if (fire) begin
      timer_r     <= timer_nxt;
      level_cnt_r <= level_cnt_nxt;
      level_out_r <= level_out_nxt;
      shift_r     <= shift_nxt;
      bits_r      <= bits_nxt;
      shifting_r  <= shifting_nxt;
      buf_full_r  <= buf_full_nxt;
      bytes_r     <= bytes_nxt;
      addr_r      <= addr_nxt;
      irq_en_r    <= irq_en_nxt;
      loop_r      <= loop_nxt;
      rate_idx_r  <= rate_idx_nxt;
      start_r     <= start_nxt;
      reload_r    <= reload_nxt;
      irq_r       <= irq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sample_buf_r <= sample_buf_nxt;
    end
  end

endmodule

`default_nettype wire
